### design/rahs_pkg.sv
// shared constants for the range allocator
package rahs_pkg;
  localparam int MAX_RANGES_DEF = 64;
  localparam int ADDR_BITS      = 32;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 33;

  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_START = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_POOL_SIZE  = 1'd1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_NOSPACE  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_LAST  = 2'd1;
  localparam logic [1:0] FIT_TIGHT = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
endpackage

### design/rahs_ram.sv
// generic single-port-write, single-read ram with registered read
module rahs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/range_allocator_hole_search.sv
// top level of the range allocator with hole search
//
//  channel  | signals                                     | transfer
//  command  | start, busy, cmd, address, req_size, ...    | start && !busy
//  result   | done, status, placed_start, pool_empty      | done, one cycle
//  config   | cfg_we, cfg_index, cfg_data                 | cfg_we
//
// an allocate keeps busy high while one pass reads entries in order to walk the holes,
// stopping early on a first fit or with stop_at_first, and a second pass shifts entries
// up one slot each through the single ram read port; a free scans and shifts entries down.
// reset clears the entry count, the pool registers and control state only.
// the result shows with done for one cycle; the receiver cannot stall.
module range_allocator_hole_search #(
  parameter int MAX_RANGES = rahs_pkg::MAX_RANGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd,
  input  logic [31:0]                        address,
  input  logic [31:0]                        req_size,
  input  logic [31:0]                        alignment,
  input  logic [31:0]                        window_start,
  input  logic [32:0]                        window_end,
  input  logic [1:0]                         fit_mode,
  input  logic                               stop_at_first,
  output logic                               done,
  output logic [2:0]                         status,
  output logic [31:0]                        placed_start,
  output logic                               pool_empty,
  input  logic                               cfg_we,
  input  logic [rahs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rahs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import rahs_pkg::*;

  localparam int IW = $clog2(MAX_RANGES);
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int W  = 66;

  typedef enum logic [3:0] {
    S_IDLE, S_WREAD, S_WALK, S_PLACE, S_SHRD, S_SHWR, S_INS,
    S_FREAD, S_FCMP, S_DRD, S_DWR, S_DONE
  } state_t;

  state_t state;
  logic [31:0] pool_start;
  logic [32:0] pool_size;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [31:0] size_q, align_q, wlo_q;
  logic [32:0] whi_q;
  logic [1:0]  mode_q;
  logic        once_q, cmd_q;
  logic [31:0] addr_q;
  logic [W-1:0] prev_end;
  logic        found;
  logic [W-1:0] best, best_len;
  logic [CW-1:0] pos;

  logic        ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [63:0] ram_wdata, ram_rdata;

  rahs_ram #(.WIDTH(64), .DEPTH(MAX_RANGES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [31:0] rd_start, rd_len;
  assign rd_start = ram_rdata[63:32];
  assign rd_len   = ram_rdata[31:0];

  logic [W-1:0] pool_end, limit;
  assign limit = W'(1) << ADDR_BITS;
  always_comb begin
    pool_end = W'(pool_start) + W'(pool_size);
    if (pool_end > limit) pool_end = limit;
  end

  // hole evaluation for current index
  logic [W-1:0] hs, he, al, am;
  logic fits, last_hole;
  always_comb begin
    last_hole = (idx == count);
    hs = prev_end;
    he = last_hole ? pool_end : W'(rd_start);
    if (hs < W'(wlo_q)) hs = W'(wlo_q);
    if (he > W'(whi_q)) he = W'(whi_q);
    am = W'(align_q) - W'(1);
    al = (align_q == 32'd0) ? hs : ((hs + am) & ~am);
    fits = (hs < he) && (al + W'(size_q) <= he);
  end

  logic sh_wr;
  assign sh_wr = (state == S_SHWR) && !(W'(rd_start) <= best);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[IW-1:0];
    unique case (state)
      S_IDLE:  ram_raddr = '0;
      S_WALK:  ram_raddr = IW'(idx + CW'(1));
      S_SHRD:  ram_raddr = IW'(idx - CW'(1));
      // entry idx has landed, copy it one slot up
      S_SHWR:  begin ram_we = sh_wr; ram_waddr = IW'(idx + CW'(1)); end
      S_INS:   begin
        ram_we = 1'b1; ram_waddr = pos[IW-1:0];
        ram_wdata = {best[31:0], size_q};
      end
      S_FCMP:  ram_raddr = IW'(idx + CW'(1));
      S_DRD:   ram_raddr = IW'(idx + CW'(1));
      // entry idx+1 has landed, copy it one slot down
      S_DWR:   ram_we = 1'b1;
      default: ram_raddr = idx[IW-1:0];
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pool_start <= '0;
      pool_size <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POOL_START: pool_start <= cfg_data[31:0];
          REG_POOL_SIZE:  pool_size <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (start) begin
          cmd_q <= cmd; addr_q <= address; size_q <= req_size;
          align_q <= alignment; wlo_q <= window_start; whi_q <= window_end;
          mode_q <= fit_mode; once_q <= stop_at_first;
          idx <= '0; found <= 1'b0; best <= '0; best_len <= '1;
          prev_end <= W'(pool_start); pos <= '0;
          if (cmd == CMD_FREE) begin
            state <= (count == '0) ? S_DONE : S_FREAD;
            status <= ST_NOTFOUND;
          end else if (req_size == 32'd0 || {1'b0, window_start} >= window_end) begin
            status <= ST_INVALID; state <= S_DONE;
          end else if (count >= CW'(MAX_RANGES)) begin
            status <= ST_FULL; state <= S_DONE;
          end else begin
            state <= S_WREAD;
          end
        end
        S_WREAD: state <= S_WALK;
        S_WALK: begin
          logic stop;
          stop = 1'b0;
          if (fits) begin
            found <= 1'b1;
            if (mode_q == FIT_LAST) best <= al;
            else if (mode_q == FIT_TIGHT) begin
              if (he - hs < best_len) begin best_len <= he - hs; best <= al; end
            end else begin best <= al; stop = 1'b1; end
            if (once_q) stop = 1'b1;
          end
          prev_end <= W'(rd_start) + W'(rd_len);
          if (stop || last_hole) begin
            state <= S_PLACE; idx <= '0;
          end else idx <= idx + CW'(1);
        end
        S_PLACE: begin
          if (!found) begin status <= ST_NOSPACE; state <= S_DONE; end
          else begin
            status <= ST_OK;
            idx <= count;
            state <= S_SHRD;
          end
        end
        // find insertion point while scanning down from the top and shifting entries up
        S_SHRD: begin
          if (idx == '0) begin
            pos <= '0; state <= S_INS;
          end else begin
            idx <= idx - CW'(1);
            state <= S_SHWR;
          end
        end
        S_SHWR: begin
          if (W'(rd_start) <= best) begin
            pos <= idx + CW'(1); state <= S_INS;
          end else begin
            state <= S_SHRD;
          end
        end
        S_INS: begin count <= count + CW'(1); state <= S_DONE; end
        S_FREAD: state <= S_FCMP;
        S_FCMP: begin
          if (rd_start == addr_q) begin
            status <= ST_OK;
            if (idx + CW'(1) == count) begin
              count <= count - CW'(1); state <= S_DONE;
            end else state <= S_DRD;
          end else if (idx + CW'(1) == count) state <= S_DONE;
          else idx <= idx + CW'(1);
        end
        S_DRD: state <= S_DWR;
        S_DWR: begin
          if (idx + CW'(2) >= count) begin
            count <= count - CW'(1); state <= S_DONE;
          end else begin
            idx <= idx + CW'(1); state <= S_DRD;
          end
        end
        S_DONE: begin
          done <= 1'b1;
          placed_start <= (status == ST_OK && cmd_q == CMD_ALLOC) ? best[31:0] : 32'd0;
          pool_empty <= (count == '0);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_RANGES)) else $error("count overflow");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("done outside idle");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transfer not taken");
  a_ins: assert property (@(posedge clk) disable iff (rst)
    state == S_INS |-> found) else $error("insert without fit");
endmodule
